[hdl/trqs_pkg.sv]
// ----------------------------------------------------------------------------
// trqs_pkg
// Shared types and constants for the thread ready-queue scheduler: op and
// status codes, controller states and the command/status groups.
// ----------------------------------------------------------------------------
package trqs_pkg;

  localparam int unsigned MAX_THREADS_DEF = 16;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_SCHED  = 2'd2,
    OP_EXIT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_SWITCHED   = 3'd0,
    ST_NO_SWITCH  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_BAD_ID     = 3'd3,
    ST_NOT_VALID  = 3'd4,
    ST_HALTED     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    HO_NONE   = 2'd0,
    HO_TARGET = 2'd1,
    HO_RUNNER = 2'd2
  } handoff_sel_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECIDE = 3'd1,
    S_SCAN   = 3'd2,
    S_FIND   = 3'd3,
    S_SHIFT  = 3'd4,
    S_APPEND = 3'd5,
    S_SWITCH = 3'd6
  } state_e;

  typedef struct packed {
    logic         capture;
    logic         scan_init;
    logic         scan_step;
    logic         create_ok;
    logic         ptr_clr;
    logic         ptr_inc;
    logic         shift_mv;
    logic         count_dec;
    logic         next_tgt;
    logic         next_head;
    logic         exit_clr;
    logic         append;
    logic         switch_run;
    logic         res_load;
    status_e      res_status;
    logic         res_new;
    handoff_sel_e res_handoff;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic range_bad;
    logic tgt_invalid;
    logic tgt_is_cur;
    logic q_empty;
    logic q_nearly_full;
    logic scan_free;
    logic scan_last;
    logic find_end;
    logic find_hit;
    logic shift_more;
  } sts_t;

endpackage

[hdl/trqs_ctrl.sv]
// ----------------------------------------------------------------------------
// trqs_ctrl
// Sequencer for the scheduler: decodes the op, steps the free-id scan, the
// queue search and the queue shift, and strobes the result.
// ----------------------------------------------------------------------------
module trqs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output logic           done_o,
  input  trqs_pkg::sts_t sts_i,
  output trqs_pkg::cmd_t cmd_o
);
  import trqs_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (sts_i.op)
          OP_CREATE: state_d = sts_i.q_nearly_full ? S_IDLE : S_SCAN;
          OP_YIELD: begin
            if (sts_i.range_bad || sts_i.tgt_invalid || sts_i.tgt_is_cur) begin
              state_d = S_IDLE;
            end else begin
              state_d = S_FIND;
            end
          end
          OP_SCHED, OP_EXIT: state_d = sts_i.q_empty ? S_IDLE : S_SHIFT;
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_free || sts_i.scan_last) state_d = S_IDLE;
      end
      S_FIND: begin
        if (sts_i.find_end) state_d = S_APPEND;
        else if (sts_i.find_hit) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (!sts_i.shift_more) state_d = (sts_i.op == OP_EXIT) ? S_SWITCH : S_APPEND;
      end
      S_APPEND: state_d = S_IDLE;
      S_SWITCH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.res_status  = ST_NO_SWITCH;
    cmd_o.res_handoff = HO_NONE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = start;
      end
      S_DECIDE: begin
        unique case (sts_i.op)
          OP_CREATE: begin
            if (sts_i.q_nearly_full) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_TABLE_FULL;
            end else begin
              cmd_o.scan_init = 1'b1;
            end
          end
          OP_YIELD: begin
            if (sts_i.range_bad) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_BAD_ID;
            end else if (sts_i.tgt_invalid) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_NOT_VALID;
            end else if (sts_i.tgt_is_cur) begin
              cmd_o.res_load    = 1'b1;
              cmd_o.res_status  = ST_NO_SWITCH;
              cmd_o.res_handoff = HO_TARGET;
            end else begin
              cmd_o.ptr_clr  = 1'b1;
              cmd_o.next_tgt = 1'b1;
            end
          end
          OP_SCHED: begin
            if (sts_i.q_empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_NO_SWITCH;
            end else begin
              cmd_o.ptr_clr   = 1'b1;
              cmd_o.next_head = 1'b1;
            end
          end
          OP_EXIT: begin
            cmd_o.exit_clr = 1'b1;
            if (sts_i.q_empty) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_HALTED;
            end else begin
              cmd_o.ptr_clr   = 1'b1;
              cmd_o.next_head = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_free) begin
          cmd_o.create_ok  = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NO_SWITCH;
          cmd_o.res_new    = 1'b1;
        end else if (sts_i.scan_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_TABLE_FULL;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FIND: begin
        if (!sts_i.find_end && !sts_i.find_hit) cmd_o.ptr_inc = 1'b1;
      end
      S_SHIFT: begin
        if (sts_i.shift_more) cmd_o.shift_mv = 1'b1;
        else cmd_o.count_dec = 1'b1;
      end
      S_APPEND: begin
        cmd_o.append      = 1'b1;
        cmd_o.switch_run  = 1'b1;
        cmd_o.res_load    = 1'b1;
        cmd_o.res_status  = ST_SWITCHED;
        cmd_o.res_handoff = (sts_i.op == OP_YIELD) ? HO_RUNNER : HO_NONE;
      end
      S_SWITCH: begin
        cmd_o.switch_run = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_SWITCHED;
      end
      default: ;
    endcase
  end

  assign done_d = cmd_o.res_load;
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

[hdl/trqs_dp.sv]
// ----------------------------------------------------------------------------
// trqs_dp
// Datapath of the scheduler: thread valid bits, ready queue, queue count,
// running and last created ids, work pointers and the result registers.
// ----------------------------------------------------------------------------
module trqs_dp #(
  parameter int unsigned MAX_THREADS = trqs_pkg::MAX_THREADS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            op_i,
  input  logic signed [7:0]     target_i,
  input  trqs_pkg::cmd_t        cmd_i,
  output trqs_pkg::sts_t        sts_o,
  output logic [2:0]            status_o,
  output logic signed [4:0]     new_id_o,
  output logic [3:0]            running_o,
  output logic signed [4:0]     handoff_o
);
  import trqs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_THREADS);
  localparam int unsigned CW = $clog2(MAX_THREADS + 1);

  logic [MAX_THREADS-1:0] valid_q, valid_d;
  logic [IW-1:0]          queue_q [MAX_THREADS];
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          cur_q, cur_d;
  logic [IW-1:0]          last_q, last_d;
  op_e                    op_q, op_d;
  logic [7:0]             tgt_q, tgt_d;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic [IW-1:0]          scan_q, scan_d;
  logic [IW-1:0]          next_q, next_d;
  status_e                res_status_q, res_status_d;
  logic [4:0]             res_new_q, res_new_d;
  logic [4:0]             res_handoff_q, res_handoff_d;

  logic [IW-1:0] tgt_id;
  logic [IW-1:0] ptr_idx;
  logic [CW-1:0] ptr_p1;
  logic [CW-1:0] ptr_wrap;
  logic [CW-1:0] last_wrap;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] rd_data;
  logic [IW-1:0] head;
  logic          append_ok;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wr_data;
  logic [7:0]    ptr_ext;
  logic [7:0]    cur_ext;

  assign tgt_id    = tgt_q[IW-1:0];
  assign ptr_idx   = ptr_q[IW-1:0];
  assign ptr_p1    = ptr_q + 1'b1;
  assign ptr_wrap  = (ptr_q == CW'(MAX_THREADS - 1)) ? '0 : ptr_p1;
  assign last_wrap = (last_q == IW'(MAX_THREADS - 1)) ? '0 : (CW'(last_q) + 1'b1);
  assign rd_addr   = cmd_i.shift_mv ? ptr_p1[IW-1:0] : ptr_idx;
  assign rd_data   = queue_q[rd_addr];
  assign head      = queue_q[0];
  assign append_ok = cmd_i.append && (count_q < CW'(MAX_THREADS));
  assign ptr_ext   = 8'(ptr_idx);
  assign cur_ext   = 8'(cur_q);

  // status towards the controller
  always_comb begin
    sts_o               = '0;
    sts_o.op            = op_q;
    sts_o.range_bad     = tgt_q[7] || (tgt_q >= 8'(MAX_THREADS));
    sts_o.tgt_invalid   = !valid_q[tgt_id];
    sts_o.tgt_is_cur    = (tgt_id == cur_q);
    sts_o.q_empty       = (count_q == '0);
    sts_o.q_nearly_full = (count_q >= CW'(MAX_THREADS - 1));
    sts_o.scan_free     = !valid_q[ptr_idx];
    sts_o.scan_last     = (scan_q == IW'(MAX_THREADS - 1));
    sts_o.find_end      = (ptr_q == count_q);
    sts_o.find_hit      = (rd_data == tgt_id);
    sts_o.shift_more    = (ptr_p1 < count_q);
  end

  // queue write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IW-1:0];
    wr_data = cur_q;
    if (cmd_i.create_ok) begin
      wr_en   = 1'b1;
      wr_data = ptr_idx;
    end else if (append_ok) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift_mv) begin
      wr_en   = 1'b1;
      wr_addr = ptr_idx;
      wr_data = rd_data;
    end
  end

  always_comb begin
    valid_d       = valid_q;
    count_d       = count_q;
    cur_d         = cur_q;
    last_d        = last_q;
    op_d          = op_q;
    tgt_d         = tgt_q;
    ptr_d         = ptr_q;
    scan_d        = scan_q;
    next_d        = next_q;
    res_status_d  = res_status_q;
    res_new_d     = res_new_q;
    res_handoff_d = res_handoff_q;

    if (cmd_i.capture) begin
      op_d  = op_e'(op_i);
      tgt_d = target_i;
    end
    if (cmd_i.create_ok) begin
      valid_d[ptr_idx] = 1'b1;
      last_d           = ptr_idx;
    end
    if (cmd_i.exit_clr) valid_d[cur_q] = 1'b0;
    if (cmd_i.create_ok || append_ok) count_d = count_q + 1'b1;
    else if (cmd_i.count_dec) count_d = count_q - 1'b1;

    if (cmd_i.scan_init) ptr_d = last_wrap;
    else if (cmd_i.scan_step) ptr_d = ptr_wrap;
    else if (cmd_i.ptr_clr) ptr_d = '0;
    else if (cmd_i.ptr_inc || cmd_i.shift_mv) ptr_d = ptr_p1;

    if (cmd_i.scan_init) scan_d = '0;
    else if (cmd_i.scan_step) scan_d = scan_q + 1'b1;

    if (cmd_i.next_tgt) next_d = tgt_id;
    else if (cmd_i.next_head) next_d = head;

    if (cmd_i.switch_run) cur_d = next_q;

    if (cmd_i.res_load) begin
      res_status_d = cmd_i.res_status;
      res_new_d    = cmd_i.res_new ? ptr_ext[4:0] : 5'h1F;
      case (cmd_i.res_handoff)
        HO_TARGET: res_handoff_d = tgt_q[4:0];
        HO_RUNNER: res_handoff_d = cur_ext[4:0];
        default:   res_handoff_d = 5'h1F;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= MAX_THREADS'(1);
      count_q <= '0;
      cur_q   <= '0;
      last_q  <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    tgt_q         <= tgt_d;
    ptr_q         <= ptr_d;
    scan_q        <= scan_d;
    next_q        <= next_d;
    res_status_q  <= res_status_d;
    res_new_q     <= res_new_d;
    res_handoff_q <= res_handoff_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) queue_q[wr_addr] <= wr_data;
  end

  assign status_o  = res_status_q;
  assign new_id_o  = res_new_q;
  assign running_o = cur_ext[3:0];
  assign handoff_o = res_handoff_q;

endmodule

[hdl/thread_ready_queue_scheduler.sv]
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler
// Timing: immediate answers are given from the decide state; create tests
//   one id per cycle, sched and exit shift the queue, and yield searches
//   and shifts it (search and shift together touch each queue entry once,
//   one entry per cycle).
// Throughput: one item at a time; start is taken again once busy falls.
// Reset: thread 0 valid and running, queue empty; the receiver cannot stall.
// ----------------------------------------------------------------------------
module thread_ready_queue_scheduler #(
  parameter int unsigned MAX_THREADS = trqs_pkg::MAX_THREADS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op_i,
  input  logic signed [7:0] target_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic signed [4:0] new_id_o,
  output logic [3:0]        running_o,
  output logic signed [4:0] handoff_o
);
  import trqs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  trqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  trqs_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op_i),
    .target_i  (target_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .status_o  (status_o),
    .new_id_o  (new_id_o),
    .running_o (running_o),
    .handoff_o (handoff_o)
  );

endmodule

[hdl/trqs_checker.sv]
// ----------------------------------------------------------------------------
// trqs_checker
// Port-level checks on the scheduler: single-cycle result strobes, busy
// around an item, defined status codes and the fixed fields of error results.
// ----------------------------------------------------------------------------
module trqs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [2:0]        status_o,
  input logic signed [4:0] new_id_o,
  input logic signed [4:0] handoff_o
);
  import trqs_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= ST_HALTED))
    else $error("undefined status code");

  a_error_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_TABLE_FULL || status_o == ST_BAD_ID ||
               status_o == ST_NOT_VALID || status_o == ST_HALTED)
      |-> (new_id_o == -5'sd1 && handoff_o == -5'sd1))
    else $error("error result carries an id");

endmodule

bind thread_ready_queue_scheduler trqs_checker u_trqs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .status_o  (status_o),
  .new_id_o  (new_id_o),
  .handoff_o (handoff_o)
);
